[design/agc_pkg.sv]
// ----------------------------------------------------------------------------
// agc_pkg: shared types and constants of the three-axis RMS gain control
// Widths, job and write structs, state types and the magnitude and saturation helpers.
// ----------------------------------------------------------------------------
package agc_pkg;

    localparam int SAMPLE_BITS     = 24;
    localparam int LENGTH_BITS     = 20;
    localparam int HALF_BITS       = 6;
    localparam int MAX_HALF_WINDOW = 63;
    localparam int DELAY_DEPTH     = 128;
    localparam int DELAY_AW        = $clog2(DELAY_DEPTH);
    localparam int DEPTH_HALF      = (DELAY_DEPTH - 1) / 2;
    localparam int HALF_CAP        = (MAX_HALF_WINDOW < DEPTH_HALF) ? MAX_HALF_WINDOW
                                                                    : DEPTH_HALF;
    localparam int GAIN_BITS       = 40;
    localparam int OUT_BITS        = 22;
    localparam int WIN_BITS        = $clog2(2 * HALF_CAP + 2);
    localparam int N3_BITS         = WIN_BITS + 2;
    localparam int PROD_BITS       = GAIN_BITS + SAMPLE_BITS;
    localparam int ENERGY_BITS     = 2 * SAMPLE_BITS + 8;
    localparam int SCALE_BITS      = 64;
    localparam int QUO_BITS        = N3_BITS + SCALE_BITS;
    localparam int SQ_BITS         = QUO_BITS + (QUO_BITS % 2);
    localparam int ROOT_BITS       = SQ_BITS / 2;
    localparam int REM_BITS        = ROOT_BITS + 3;
    localparam int CNT_BITS        = $clog2(QUO_BITS);
    localparam int FIFO_DEPTH      = 2;
    localparam int FIFO_AW         = $clog2(FIFO_DEPTH);
    localparam int IN_DATA_BITS    = ((3 * SAMPLE_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_BITS   = ((GAIN_BITS + 3 * OUT_BITS + 7) / 8) * 8;
    localparam int CFG_IDX_BITS    = 1;
    localparam int CFG_DATA_BITS   = LENGTH_BITS;

    localparam logic [CFG_IDX_BITS-1:0] CFG_HALF_SPAN    = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] CFG_TRACE_LENGTH = CFG_IDX_BITS'(1);

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [OUT_BITS-1:0]    out_t;

    typedef struct packed {
        logic [LENGTH_BITS-1:0] j;
        logic [LENGTH_BITS-1:0] lm1;
        logic [HALF_BITS-1:0]   h;
        logic                   last;
    } job_t;

    typedef struct packed {
        logic                      en;
        logic [DELAY_AW-1:0]       addr;
        logic [3*SAMPLE_BITS-1:0]  data;
    } mem_wr_t;

    typedef enum logic {
        F_IDLE,
        F_GEN
    } front_state_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_PLAN,
        B_SQ0,
        B_SQ1,
        B_SQ2,
        B_SQ3,
        B_DIVSET,
        B_DIV,
        B_SQSET,
        B_SQRT,
        B_MUL0,
        B_MUL1,
        B_MUL2,
        B_MUL3,
        B_OUT
    } back_state_t;

    // Magnitude of a signed sample; the most negative value maps onto 2^(n-1).
    function automatic logic [SAMPLE_BITS-1:0] sample_mag(input sample_t x);
        logic [SAMPLE_BITS-1:0] u;
        u = x;
        return x[SAMPLE_BITS-1] ? (~u + SAMPLE_BITS'(1)) : u;
    endfunction

    // Scale the product down by 2^16, apply the sign and saturate.
    function automatic out_t sat_out(input logic [PROD_BITS-1:0] prod, input logic neg);
        logic [PROD_BITS-17:0] p;
        logic [PROD_BITS-17:0] pos_lim;
        logic [PROD_BITS-17:0] neg_lim;
        logic [OUT_BITS-1:0]   r;
        p       = prod[PROD_BITS-1:16];
        pos_lim = (PROD_BITS-16)'((64'd1 << (OUT_BITS - 1)) - 64'd1);
        neg_lim = (PROD_BITS-16)'(64'd1 << (OUT_BITS - 1));
        if (neg)
        begin
            if (p > neg_lim)
                r = neg_lim[OUT_BITS-1:0];
            else
                r = ~p[OUT_BITS-1:0] + OUT_BITS'(1);
        end
        else
        begin
            if (p > pos_lim)
                r = pos_lim[OUT_BITS-1:0];
            else
                r = p[OUT_BITS-1:0];
        end
        return out_t'(r);
    endfunction

endpackage

[design/agc_front.sv]
// ----------------------------------------------------------------------------
// agc_front: input side of the gain control
// Takes sample words, writes the delay line, tracks the trace and queues jobs.
// ----------------------------------------------------------------------------
module agc_front
    import agc_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  cfg_idx,
    input  logic [CFG_DATA_BITS-1:0] cfg_data,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [IN_DATA_BITS-1:0]  s_tdata,
    input  logic                     back_idle,
    input  logic                     fifo_full,
    input  logic                     fifo_empty,
    output logic                     push,
    output job_t                     job,
    output mem_wr_t                  wr
);

    front_state_t           state_reg, state_next;
    logic [HALF_BITS-1:0]   half_span_reg;
    logic [LENGTH_BITS-1:0] trace_length_reg;
    logic [LENGTH_BITS-1:0] sin_reg, sin_next;
    logic [LENGTH_BITS-1:0] sout_reg, sout_next;
    logic [LENGTH_BITS-1:0] lm1_reg, lm1_next;
    logic [HALF_BITS-1:0]   h_reg, h_next;

    logic                   accept;
    logic                   emit;
    logic [LENGTH_BITS-1:0] len_eff;
    logic [LENGTH_BITS-1:0] lm1_new;
    logic [LENGTH_BITS-1:0] half_lim;
    logic [HALF_BITS-1:0]   h_new;
    logic [LENGTH_BITS:0]   sout_plus_h;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_span_reg    <= '0;
            trace_length_reg <= LENGTH_BITS'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                CFG_HALF_SPAN:    half_span_reg    <= cfg_data[HALF_BITS-1:0];
                CFG_TRACE_LENGTH: trace_length_reg <= cfg_data[LENGTH_BITS-1:0];
                default:          ;
            endcase
        end
    end

    // Window limits for a trace that starts with the next word.
    always_comb
    begin
        len_eff  = (trace_length_reg == '0) ? LENGTH_BITS'(1) : trace_length_reg;
        lm1_new  = len_eff - LENGTH_BITS'(1);
        half_lim = lm1_new >> 1;
        h_new    = half_span_reg;
        if (h_new > HALF_BITS'(HALF_CAP))
            h_new = HALF_BITS'(HALF_CAP);
        if (LENGTH_BITS'(h_new) > half_lim)
            h_new = half_lim[HALF_BITS-1:0];
    end

    assign sout_plus_h = {1'b0, sout_reg} + (LENGTH_BITS+1)'(h_reg);
    assign emit = (sout_reg < sin_reg) &&
                  ((sout_plus_h < {1'b0, sin_reg}) || (sin_reg > lm1_reg));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE:  if (accept) state_next = F_GEN;
            F_GEN:   if (!emit) state_next = F_IDLE;
            default: state_next = F_IDLE;
        endcase
    end

    always_comb
    begin
        s_tready  = (state_reg == F_IDLE) && back_idle && fifo_empty;
        accept    = s_tvalid && s_tready;
        push      = (state_reg == F_GEN) && emit && !fifo_full;
        job.j     = sout_reg;
        job.lm1   = lm1_reg;
        job.h     = h_reg;
        job.last  = (sout_reg == lm1_reg);
        wr.en     = accept;
        wr.addr   = sin_reg[DELAY_AW-1:0];
        wr.data   = s_tdata[3*SAMPLE_BITS-1:0];
        sin_next  = sin_reg;
        sout_next = sout_reg;
        lm1_next  = lm1_reg;
        h_next    = h_reg;
        if (accept)
        begin
            if (sin_reg == '0)
            begin
                lm1_next  = lm1_new;
                h_next    = h_new;
                sout_next = '0;
            end
            sin_next = sin_reg + LENGTH_BITS'(1);
        end
        else if (push)
        begin
            sout_next = sout_reg + LENGTH_BITS'(1);
        end
        else if ((state_reg == F_GEN) && !emit && (sin_reg > lm1_reg))
        begin
            sin_next  = '0;
            sout_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            sin_reg   <= '0;
            sout_reg  <= '0;
            lm1_reg   <= '0;
            h_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            sin_reg   <= sin_next;
            sout_reg  <= sout_next;
            lm1_reg   <= lm1_next;
            h_reg     <= h_next;
        end
    end

endmodule

[design/agc_fifo.sv]
// ----------------------------------------------------------------------------
// agc_fifo: short job queue between the front and back ends
// Two entries, simultaneous push and pop allowed.
// ----------------------------------------------------------------------------
module agc_fifo
    import agc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    input  logic pop,
    output job_t pop_job,
    output logic full,
    output logic empty
);

    job_t                 entry_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg;
    logic [FIFO_AW-1:0]   rd_ptr_reg;
    logic [FIFO_AW:0]     count_reg;

    assign full    = (count_reg == (FIFO_AW+1)'(FIFO_DEPTH));
    assign empty   = (count_reg == '0);
    assign pop_job = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + FIFO_AW'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + FIFO_AW'(1);
            if (push && !pop)
                count_reg <= count_reg + (FIFO_AW+1)'(1);
            else if (pop && !push)
                count_reg <= count_reg - (FIFO_AW+1)'(1);
        end
    end

endmodule

[design/agc_back.sv]
// ----------------------------------------------------------------------------
// agc_back: window energy, inverse RMS and gain sequencer
// Holds the delay line, slides the window, divides, takes the root, scales.
// ----------------------------------------------------------------------------
module agc_back
    import agc_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  mem_wr_t                  wr,
    input  logic                     fifo_empty,
    input  job_t                     fifo_job,
    output logic                     pop,
    output logic                     idle,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [OUT_DATA_BITS-1:0] m_tdata,
    output logic                     m_tlast
);

    logic [3*SAMPLE_BITS-1:0] mem [DELAY_DEPTH];
    logic [3*SAMPLE_BITS-1:0] rd_data_reg;
    logic                     rd_en;
    logic [DELAY_AW-1:0]      rd_addr;

    back_state_t              state_reg, state_next;
    job_t                     job_reg, job_next;
    logic [ENERGY_BITS-1:0]   energy_reg, energy_next;
    logic [LENGTH_BITS-1:0]   lo_reg, lo_next;
    logic [LENGTH_BITS-1:0]   hi_reg, hi_next;
    logic                     sub_reg, sub_next;
    logic [PROD_BITS-1:0]     prod_reg, prod_next;
    logic [ENERGY_BITS-1:0]   rem_reg, rem_next;
    logic [QUO_BITS-1:0]      quo_reg, quo_next;
    logic [SQ_BITS-1:0]       sq_reg, sq_next;
    logic [REM_BITS-1:0]      srem_reg, srem_next;
    logic [ROOT_BITS-1:0]     root_reg, root_next;
    logic [CNT_BITS-1:0]      cnt_reg, cnt_next;
    logic [GAIN_BITS-1:0]     gain_reg, gain_next;
    out_t                     res_a_reg, res_a_next;
    out_t                     res_b_reg, res_b_next;
    out_t                     res_c_reg, res_c_next;
    logic                     valid_reg, valid_next;
    logic [GAIN_BITS-1:0]     o_gain_reg;
    out_t                     o_a_reg, o_b_reg, o_c_reg;
    logic                     o_last_reg;
    logic                     load_out;

    sample_t                  smp_a, smp_b, smp_c;
    logic [LENGTH_BITS:0]     jh;
    logic [LENGTH_BITS-1:0]   thi, tlo;
    logic [WIN_BITS-1:0]      win_n;
    logic [N3_BITS-1:0]       n3;
    logic [GAIN_BITS-1:0]     mul_x;
    logic [SAMPLE_BITS-1:0]   mul_y;
    logic [ENERGY_BITS:0]     rem_sh;
    logic                     div_ge;
    logic [REM_BITS-1:0]      sq_r, sq_trial;
    logic                     sq_ge;
    logic                     need_add, need_sub;

    always_ff @(posedge clk)
    begin
        if (wr.en)
            mem[wr.addr] <= wr.data;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    assign smp_a = sample_t'(rd_data_reg[SAMPLE_BITS-1:0]);
    assign smp_b = sample_t'(rd_data_reg[2*SAMPLE_BITS-1:SAMPLE_BITS]);
    assign smp_c = sample_t'(rd_data_reg[3*SAMPLE_BITS-1:2*SAMPLE_BITS]);

    // Clipped window [tlo, thi) of the current job.
    always_comb
    begin
        jh    = {1'b0, job_reg.j} + (LENGTH_BITS+1)'(job_reg.h);
        thi   = ((jh > {1'b0, job_reg.lm1}) ? job_reg.lm1 : jh[LENGTH_BITS-1:0])
                + LENGTH_BITS'(1);
        tlo   = (job_reg.j > LENGTH_BITS'(job_reg.h)) ?
                (job_reg.j - LENGTH_BITS'(job_reg.h)) : '0;
        win_n = WIN_BITS'(thi - tlo);
        n3    = {win_n, 1'b0} + N3_BITS'(win_n);
    end

    assign need_add = (hi_reg < thi);
    assign need_sub = (lo_reg < tlo);

    assign rem_sh   = {rem_reg, quo_reg[QUO_BITS-1]};
    assign div_ge   = (rem_sh >= {1'b0, energy_reg});
    assign sq_r     = {srem_reg[REM_BITS-3:0], sq_reg[SQ_BITS-1:SQ_BITS-2]};
    assign sq_trial = REM_BITS'({root_reg, 2'b01});
    assign sq_ge    = (sq_r >= sq_trial);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:   if (!fifo_empty) state_next = B_PLAN;
            B_PLAN:   state_next = (need_add || need_sub) ? B_SQ0 : B_DIVSET;
            B_SQ0:    state_next = B_SQ1;
            B_SQ1:    state_next = B_SQ2;
            B_SQ2:    state_next = B_SQ3;
            B_SQ3:    state_next = B_PLAN;
            B_DIVSET: state_next = (energy_reg == '0) ? B_MUL0 : B_DIV;
            B_DIV:    if (cnt_reg == '0) state_next = B_SQSET;
            B_SQSET:  state_next = B_SQRT;
            B_SQRT:   if (cnt_reg == '0) state_next = B_MUL0;
            B_MUL0:   state_next = B_MUL1;
            B_MUL1:   state_next = B_MUL2;
            B_MUL2:   state_next = B_MUL3;
            B_MUL3:   state_next = B_OUT;
            B_OUT:    if (!valid_reg || m_tready) state_next = B_IDLE;
            default:  state_next = B_IDLE;
        endcase
    end

    always_comb
    begin
        pop         = 1'b0;
        rd_en       = 1'b0;
        rd_addr     = hi_reg[DELAY_AW-1:0];
        mul_x       = '0;
        mul_y       = '0;
        load_out    = 1'b0;
        job_next    = job_reg;
        energy_next = energy_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        sub_next    = sub_reg;
        prod_next   = prod_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        sq_next     = sq_reg;
        srem_next   = srem_reg;
        root_next   = root_reg;
        cnt_next    = cnt_reg;
        gain_next   = gain_reg;
        res_a_next  = res_a_reg;
        res_b_next  = res_b_reg;
        res_c_next  = res_c_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (!fifo_empty)
                begin
                    pop      = 1'b1;
                    job_next = fifo_job;
                    if (fifo_job.j == '0)
                    begin
                        energy_next = '0;
                        lo_next     = '0;
                        hi_next     = '0;
                    end
                end
            end
            B_PLAN:
            begin
                rd_en = 1'b1;
                if (need_add)
                begin
                    rd_addr  = hi_reg[DELAY_AW-1:0];
                    sub_next = 1'b0;
                    hi_next  = hi_reg + LENGTH_BITS'(1);
                end
                else if (need_sub)
                begin
                    rd_addr  = lo_reg[DELAY_AW-1:0];
                    sub_next = 1'b1;
                    lo_next  = lo_reg + LENGTH_BITS'(1);
                end
                else
                begin
                    rd_addr = job_reg.j[DELAY_AW-1:0];
                end
            end
            B_SQ0, B_SQ1, B_SQ2, B_SQ3:
            begin
                if (state_reg != B_SQ0)
                    energy_next = sub_reg ? (energy_reg - prod_reg[ENERGY_BITS-1:0])
                                          : (energy_reg + prod_reg[ENERGY_BITS-1:0]);
                case (state_reg)
                    B_SQ0:   mul_y = sample_mag(smp_a);
                    B_SQ1:   mul_y = sample_mag(smp_b);
                    default: mul_y = sample_mag(smp_c);
                endcase
                mul_x = GAIN_BITS'(mul_y);
                if (state_reg != B_SQ3)
                    prod_next = mul_x * mul_y;
            end
            B_DIVSET:
            begin
                gain_next = '0;
                rem_next  = '0;
                quo_next  = {n3, SCALE_BITS'(0)};
                cnt_next  = CNT_BITS'(QUO_BITS - 1);
            end
            B_DIV:
            begin
                rem_next = div_ge ? ENERGY_BITS'(rem_sh - {1'b0, energy_reg})
                                  : rem_sh[ENERGY_BITS-1:0];
                quo_next = {quo_reg[QUO_BITS-2:0], div_ge};
                cnt_next = cnt_reg - CNT_BITS'(1);
            end
            B_SQSET:
            begin
                sq_next   = SQ_BITS'(quo_reg);
                srem_next = '0;
                root_next = '0;
                cnt_next  = CNT_BITS'(ROOT_BITS - 1);
            end
            B_SQRT:
            begin
                srem_next = sq_ge ? (sq_r - sq_trial) : sq_r;
                root_next = {root_reg[ROOT_BITS-2:0], sq_ge};
                sq_next   = {sq_reg[SQ_BITS-3:0], 2'b00};
                cnt_next  = cnt_reg - CNT_BITS'(1);
                gain_next = GAIN_BITS'(root_next);
            end
            B_MUL0, B_MUL1, B_MUL2, B_MUL3:
            begin
                mul_x = gain_reg;
                case (state_reg)
                    B_MUL0:
                    begin
                        mul_y = sample_mag(smp_a);
                    end
                    B_MUL1:
                    begin
                        res_a_next = sat_out(prod_reg, smp_a[SAMPLE_BITS-1]);
                        mul_y      = sample_mag(smp_b);
                    end
                    B_MUL2:
                    begin
                        res_b_next = sat_out(prod_reg, smp_b[SAMPLE_BITS-1]);
                        mul_y      = sample_mag(smp_c);
                    end
                    default:
                    begin
                        res_c_next = sat_out(prod_reg, smp_c[SAMPLE_BITS-1]);
                    end
                endcase
                if (state_reg != B_MUL3)
                    prod_next = mul_x * mul_y;
            end
            B_OUT:
            begin
                load_out = !valid_reg || m_tready;
            end
            default:
            begin
            end
        endcase
    end

    assign valid_next = load_out ? 1'b1 : (m_tready ? 1'b0 : valid_reg);
    assign idle       = (state_reg == B_IDLE);
    assign m_tvalid   = valid_reg;
    assign m_tlast    = o_last_reg;
    assign m_tdata    = OUT_DATA_BITS'({o_c_reg, o_b_reg, o_a_reg, o_gain_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= B_IDLE;
            valid_reg  <= 1'b0;
            energy_reg <= '0;
            lo_reg     <= '0;
            hi_reg     <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            valid_reg  <= valid_next;
            energy_reg <= energy_next;
            lo_reg     <= lo_next;
            hi_reg     <= hi_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg   <= job_next;
        sub_reg   <= sub_next;
        prod_reg  <= prod_next;
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        sq_reg    <= sq_next;
        srem_reg  <= srem_next;
        root_reg  <= root_next;
        gain_reg  <= gain_next;
        res_a_reg <= res_a_next;
        res_b_reg <= res_b_next;
        res_c_reg <= res_c_next;
        if (load_out)
        begin
            o_gain_reg <= gain_reg;
            o_a_reg    <= res_a_reg;
            o_b_reg    <= res_b_reg;
            o_c_reg    <= res_c_reg;
            o_last_reg <= job_reg.last;
        end
    end

endmodule

[design/three_axis_rms_agc.sv]
// With two window moves, a result word is presented after the back end takes its job
// and runs the look-up, 73 division steps, 37 root steps, the scaling and the hand-over;
// a window with zero energy skips both the division and the root.
// The first result of a trace spends up to 64 window adds in place of the two moves.
// Input words are taken only when the single back-end sequencer is idle and the job queue is empty.
// Reset clears all control state; the delay line needs no clearing pass.
// ----------------------------------------------------------------------------
// three_axis_rms_agc: three-component sliding-window RMS gain control
// Normalises each three-axis sample by the inverse RMS of a centred window.
// ----------------------------------------------------------------------------
module three_axis_rms_agc
    import agc_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    // Configuration: index 0 half span, index 1 trace_length.
    input  logic                     cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  cfg_idx,
    input  logic [CFG_DATA_BITS-1:0] cfg_data,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    // s_tdata from bit 0: comp_a, comp_b, comp_c.
    input  logic [IN_DATA_BITS-1:0]  s_tdata,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    // m_tdata from bit 0: gain, out_a, out_b, out_c, zero padding.
    output logic [OUT_DATA_BITS-1:0] m_tdata,
    // m_tlast marks the word of the final trace sample.
    output logic                     m_tlast
);

    // The front end takes a word only when the back end is idle and the job
    // queue is empty, so the delay line slot it overwrites can no longer be in
    // any window still to be processed. It then queues one job per result the
    // word releases, and the whole flush at the end of a trace.
    logic    back_idle;
    logic    fifo_full;
    logic    fifo_empty;
    logic    fifo_push;
    logic    fifo_pop;
    job_t    push_job;
    job_t    pop_job;
    mem_wr_t wr;

    agc_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_idx    (cfg_idx),
        .cfg_data   (cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .back_idle  (back_idle),
        .fifo_full  (fifo_full),
        .fifo_empty (fifo_empty),
        .push       (fifo_push),
        .job        (push_job),
        .wr         (wr)
    );

    agc_fifo u_fifo
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (fifo_push),
        .push_job (push_job),
        .pop      (fifo_pop),
        .pop_job  (pop_job),
        .full     (fifo_full),
        .empty    (fifo_empty)
    );

    // The back end slides the window one sample at a time, keeping a running
    // energy sum, then forms floor(sqrt(3n * 2^64 / E)) by long division and a
    // digit-by-digit root, and scales the three components with one multiplier.
    agc_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr         (wr),
        .fifo_empty (fifo_empty),
        .fifo_job   (pop_job),
        .pop        (fifo_pop),
        .idle       (back_idle),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

    a_one_word_per_pass: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken on two successive cycles");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_push |-> !fifo_full)
        else $error("job queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_pop |-> !fifo_empty)
        else $error("job queue read while empty");

endmodule
